// ----- hw/rtl/lddc_pkg.sv -----
// Shared types and constants for the CRC-8 checked line deframer.
// No dependencies; imported by every module of the block.
package lddc_pkg;

  // Field widths fixed by the interface.
  localparam int BYTE_W = 8;
  localparam int PLEN_W = 6;
  localparam int STAT_W = 2;

  // CRC-8, polynomial x^8 + x^2 + x + 1, initial value zero.
  localparam logic [BYTE_W-1:0] CRC_POLY = 8'h07;
  localparam logic [BYTE_W-1:0] CRC_INIT = 8'h00;

  // Characters that steer the framing.
  localparam logic [BYTE_W-1:0] CH_LF   = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR   = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_STAR = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;

  // Line status codes.
  localparam logic [STAT_W-1:0] LS_PLAIN  = 2'd0;
  localparam logic [STAT_W-1:0] LS_MATCH  = 2'd1;
  localparam logic [STAT_W-1:0] LS_REJECT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_READ,
    ST_OUT,
    ST_STAT
  } lddc_state_t;

  // Status of the shared CRC unit as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } crc_stat_t;

endpackage

// ----- hw/rtl/lddc_crc_unit.sv -----
// Shared CRC-8 unit: folds one byte into a CRC two bits per cycle.
// Depends on lddc_pkg for the polynomial and the status struct.
module lddc_crc_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start_i,
  input  logic [7:0]                byte_i,
  input  logic [7:0]                crc_i,
  output logic [7:0]                crc_o,
  output lddc_pkg::crc_stat_t       stat_o
);
  import lddc_pkg::*;

  logic [BYTE_W-1:0] c_r;
  logic [1:0]        cnt_r;
  logic              busy_r;

  function automatic logic [BYTE_W-1:0] crc_bit(input logic [BYTE_W-1:0] c);
    crc_bit = c[BYTE_W-1] ? ({c[BYTE_W-2:0], 1'b0} ^ CRC_POLY) : {c[BYTE_W-2:0], 1'b0};
  endfunction

  // Two shift steps of the division per cycle.
  assign crc_o       = crc_bit(crc_bit(c_r));
  assign stat_o.busy = busy_r;
  assign stat_o.done = busy_r && (cnt_r == 2'd3);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (start_i) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      c_r <= crc_i ^ byte_i;
    end else if (busy_r) begin
      c_r <= crc_o;
    end
  end

endmodule

// ----- hw/rtl/lddc_line_mem.sv -----
// Line store: single write port, one registered read port.
// Depends on lddc_pkg for the byte width.
module lddc_line_mem #(
  parameter int DEPTH = 63,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [7:0]    wr_data_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [7:0]    rd_data_o
);
  import lddc_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_r <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_r;

endmodule

// ----- hw/rtl/line_deframer_crc8_check_top.sv -----
// CRC-8 checked text line receiver, top level with the line sequencer.
// Depends on lddc_pkg, lddc_crc_unit and lddc_line_mem.
//
// Usage: received bytes enter on the in_ channel, one per transfer. Bytes are
// kept in the line store until a line feed; carriage returns are discarded,
// and bytes that arrive while the store is full are dropped. A zero byte ends
// the usable text. The last '*' splits payload from a hex checksum, which is
// checked against the CRC-8 (polynomial 0x07, initial value zero) of the
// payload.
// A stored text byte is taken in the idle state, after which the block waits
// in the CRC state while the shared CRC unit folds it in two bits per cycle.
// Carriage returns, dropped bytes and bytes after a zero byte skip that wait.
// On a line feed the block emits the payload bytes on the out_ channel,
// then one status transfer with out_is_status and out_last high. A rejected
// line gives only the status transfer. Each payload transfer passes a memory
// read state and then a presentation state that holds through any stall, and
// the status transfer holds likewise; after it the next byte is taken.
// While the block emits or computes, in_ready is low. When the receiver
// stalls, the current result holds on the out_ ports until it is taken.
// Reset clears the sequencer and all line state; the store contents are left
// as they are, since only written entries are ever read back.
module line_deframer_crc8_check_top #(
  parameter int LINE_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data_byte,
  output logic       out_is_status,
  output logic [1:0] out_line_status,
  output logic [5:0] out_payload_length,
  output logic       out_last
);
  import lddc_pkg::*;

  // Counter width: the count can reach the store depth of LINE_BYTES-1.
  localparam int CW    = $clog2(LINE_BYTES);
  localparam int DEPTH = LINE_BYTES - 1;

  lddc_state_t       state_r, state_nxt;
  logic [CW-1:0]     count_r;
  logic [BYTE_W-1:0] crc_r;
  logic [BYTE_W-1:0] star_crc_r;
  logic              star_seen_r;
  logic [CW-1:0]     star_pos_r;
  logic [BYTE_W-1:0] hex_r;
  logic              hex_stop_r;
  logic              zero_seen_r;
  logic [CW-1:0]     zero_pos_r;
  logic [CW-1:0]     len_r;
  logic [STAT_W-1:0] status_r;
  logic [CW-1:0]     idx_r;

  logic              in_fire, out_fire;
  logic              is_lf, is_cr, full, store_en, crc_start;
  logic [CW-1:0]     line_len;
  logic [STAT_W-1:0] line_status;
  logic [4:0]        digit;
  logic [BYTE_W-1:0] crc_out, rd_data;
  crc_stat_t         crc_st;

  // Hex digit decode; bit 4 flags a non-hex character.
  function automatic logic [4:0] hex_decode(input logic [7:0] b);
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_decode = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_decode = {1'b0, 4'(b - 8'h57)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_decode = {1'b0, 4'(b - 8'h37)};
    end else begin
      hex_decode = 5'h10;
    end
  endfunction

  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;
  assign is_lf     = (in_rx_byte == CH_LF);
  assign is_cr     = (in_rx_byte == CH_CR);
  assign full      = (count_r == CW'(DEPTH));
  assign store_en  = in_fire && !is_lf && !is_cr && !full;
  assign crc_start = store_en && !zero_seen_r;
  assign digit     = hex_decode(in_rx_byte);

  // Payload length and verdict as they stand when the line feed arrives.
  assign line_len = star_seen_r ? star_pos_r : (zero_seen_r ? zero_pos_r : count_r);
  assign line_status = !star_seen_r ? LS_PLAIN :
                       (hex_r == star_crc_r) ? LS_MATCH : LS_REJECT;

  lddc_crc_unit u_crc (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (crc_start),
    .byte_i  (in_rx_byte),
    .crc_i   (crc_r),
    .crc_o   (crc_out),
    .stat_o  (crc_st)
  );

  lddc_line_mem #(
    .DEPTH (DEPTH),
    .AW    (CW)
  ) u_mem (
    .clk       (clk),
    .wr_en_i   (store_en),
    .wr_addr_i (count_r),
    .wr_data_i (in_rx_byte),
    .rd_addr_i (idx_r),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt          = state_r;
    in_ready           = 1'b0;
    out_valid          = 1'b0;
    out_data_byte      = CH_NUL;
    out_is_status      = 1'b0;
    out_last           = 1'b0;
    out_line_status    = status_r;
    out_payload_length = PLEN_W'(len_r);
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (is_lf) begin
            if (line_status != LS_REJECT && line_len != '0) begin
              state_nxt = ST_READ;
            end else begin
              state_nxt = ST_STAT;
            end
          end else if (crc_start) begin
            state_nxt = ST_CRC;
          end
        end
      end
      ST_CRC: begin
        if (crc_st.done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_READ: begin
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        out_valid     = 1'b1;
        out_data_byte = rd_data;
        if (out_ready) begin
          state_nxt = (idx_r + CW'(1) == len_r) ? ST_STAT : ST_READ;
        end
      end
      ST_STAT: begin
        out_valid     = 1'b1;
        out_is_status = 1'b1;
        out_last      = 1'b1;
        if (out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Line state: updated as bytes are stored, cleared by every line feed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      crc_r       <= CRC_INIT;
      star_crc_r  <= CRC_INIT;
      star_seen_r <= 1'b0;
      star_pos_r  <= '0;
      hex_r       <= '0;
      hex_stop_r  <= 1'b0;
      zero_seen_r <= 1'b0;
      zero_pos_r  <= '0;
    end else if (in_fire && is_lf) begin
      count_r     <= '0;
      crc_r       <= CRC_INIT;
      star_crc_r  <= CRC_INIT;
      star_seen_r <= 1'b0;
      star_pos_r  <= '0;
      hex_r       <= '0;
      hex_stop_r  <= 1'b0;
      zero_seen_r <= 1'b0;
      zero_pos_r  <= '0;
    end else begin
      if (store_en) begin
        count_r <= count_r + CW'(1);
      end
      if (crc_start) begin
        if (in_rx_byte == CH_NUL) begin
          zero_seen_r <= 1'b1;
          zero_pos_r  <= count_r;
          hex_stop_r  <= 1'b1;
        end else if (in_rx_byte == CH_STAR) begin
          star_seen_r <= 1'b1;
          star_pos_r  <= count_r;
          star_crc_r  <= crc_r;
          hex_r       <= '0;
          hex_stop_r  <= 1'b0;
        end else if (star_seen_r && !hex_stop_r) begin
          if (digit[4]) begin
            hex_stop_r <= 1'b1;
          end else begin
            hex_r <= {hex_r[3:0], digit[3:0]};
          end
        end
      end
      if (state_r == ST_CRC && crc_st.done) begin
        crc_r <= crc_out;
      end
    end
  end

  // Emission bookkeeping: the verdict is latched at the line feed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r    <= '0;
      len_r    <= '0;
      status_r <= LS_PLAIN;
    end else if (in_fire && is_lf) begin
      idx_r    <= '0;
      len_r    <= line_len;
      status_r <= line_status;
    end else if (state_r == ST_OUT && out_fire) begin
      idx_r <= idx_r + CW'(1);
    end
  end

  // The sequencer never takes a byte while it is offering a result.
  a_excl_hs: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input and output handshakes active together");

  // Payload reads stay inside the latched payload length.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> (idx_r < len_r))
    else $error("payload read beyond line length");

  // The fill count never passes the store depth.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("line store count overflow");

  // A rejected line goes straight to its status transfer.
  a_reject_stat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && is_lf && line_status == LS_REJECT) |=> (state_r == ST_STAT))
    else $error("rejected line emitted payload");

  // The CRC unit only runs while the sequencer waits for it.
  a_crc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    crc_st.busy |-> (state_r == ST_CRC))
    else $error("CRC unit running outside its wait state");

endmodule

// ----- verif/line_deframer_crc8_check_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for line_deframer_crc8_check_top: random lines in, results checked.
// Depends on lddc_pkg and the RTL of the block; needs no other file.

import lddc_pkg::*;

// Parameter of the block under test; the line store keeps one byte fewer.
localparam int TB_LINE_BYTES = 64;

typedef struct packed {
  logic [BYTE_W-1:0] data_byte;
  logic              is_status;
  logic [STAT_W-1:0] line_status;
  logic [PLEN_W-1:0] payload_length;
  logic              last;
} line_item_t;

// One byte through CRC-8, polynomial 0x07, MSB first.
function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
  logic [7:0] c;
  c = crc ^ b;
  for (int k = 0; k < 8; k++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
  return c;
endfunction

function automatic int hex_nibble(input logic [7:0] b);
  if (b >= "0" && b <= "9") return b - "0";
  if (b >= "a" && b <= "f") return b - "a" + 10;
  if (b >= "A" && b <= "F") return b - "A" + 10;
  return -1;
endfunction

class line_result_tracker;
  logic [7:0]        text_store [TB_LINE_BYTES-1];
  logic [PLEN_W-1:0] text_len;
  logic [7:0]        crc_so_far;
  logic [7:0]        crc_before_star;
  bit                star_found;
  logic [PLEN_W-1:0] star_at;
  logic [7:0]        sum_digits;
  bit                sum_halted;
  bit                nul_found;
  line_item_t        awaited[$];
  int unsigned       mismatch_count;

  function new();
    mismatch_count = 0;
    clear_line();
  endfunction

  function void clear_line();
    text_len        = '0;
    crc_so_far      = CRC_INIT;
    crc_before_star = CRC_INIT;
    star_found      = 1'b0;
    star_at         = '0;
    sum_digits      = '0;
    sum_halted      = 1'b0;
    nul_found       = 1'b0;
  endfunction

  function int pending();
    return awaited.size();
  endfunction

  // Works out what one accepted byte does to the line and queues its results.
  function void note_rx_byte(input logic [7:0] b);
    logic [PLEN_W-1:0] plen;
    logic [STAT_W-1:0] status;
    bit                emit;
    int                nib;
    line_item_t        item;
    if (b == CH_LF) begin
      plen = '0;
      if (star_found) begin
        plen   = star_at;
        status = (sum_digits == crc_before_star) ? LS_MATCH : LS_REJECT;
        emit   = (status == LS_MATCH);
      end else begin
        while (plen < text_len && text_store[plen] != CH_NUL) plen++;
        status = LS_PLAIN;
        emit   = 1'b1;
      end
      if (emit) begin
        for (int i = 0; i < plen; i++) begin
          item = '{data_byte: text_store[i], is_status: 1'b0, line_status: status,
                   payload_length: plen, last: 1'b0};
          awaited.push_back(item);
        end
      end
      item = '{data_byte: CH_NUL, is_status: 1'b1, line_status: status,
               payload_length: plen, last: 1'b1};
      awaited.push_back(item);
      clear_line();
    end else if (b != CH_CR && text_len < TB_LINE_BYTES - 1) begin
      text_store[text_len] = b;
      if (!nul_found) begin
        if (b == CH_NUL) begin
          nul_found  = 1'b1;
          sum_halted = 1'b1;
        end else if (b == CH_STAR) begin
          star_found      = 1'b1;
          star_at         = text_len;
          crc_before_star = crc_so_far;
          sum_digits      = '0;
          sum_halted      = 1'b0;
        end else if (star_found && !sum_halted) begin
          nib = hex_nibble(b);
          if (nib < 0) sum_halted = 1'b1;
          else sum_digits = {sum_digits[3:0], nib[3:0]};
        end
        crc_so_far = crc8_fold(crc_so_far, b);
      end
      text_len++;
    end
  endfunction

  task flag_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task compare_field(input string name, input int got, input int want);
    if (got != want) flag_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task check_line_item(input line_item_t got);
    line_item_t want;
    if (awaited.size() == 0) begin
      flag_mismatch($sformatf("result with nothing awaited (data 0x%02h, status flag %0b)",
                              got.data_byte, got.is_status));
      return;
    end
    want = awaited.pop_front();
    compare_field("data_byte", int'(got.data_byte), int'(want.data_byte));
    compare_field("is_status", int'(got.is_status), int'(want.is_status));
    compare_field("line_status", int'(got.line_status), int'(want.line_status));
    compare_field("payload_length", int'(got.payload_length), int'(want.payload_length));
    compare_field("last", int'(got.last), int'(want.last));
  endtask
endclass

module line_deframer_crc8_check_top_tb;

  // No new line starts once this many bytes have been taken, and both sides
  // stop idling for the final stretch of that count.
  localparam int TARGET_ITEMS     = 255;
  localparam int CALM_ITEMS       = 40;
  localparam int MAX_GAP          = 11;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int DRAIN_LIMIT      = 5000;
  localparam int SETTLE_CYCLES    = 16;
  localparam int RUN_LIMIT_NS     = 2_000_000;

  typedef enum int {
    SHAPE_CHECKED,
    SHAPE_PLAIN,
    SHAPE_MULTI_STAR,
    SHAPE_NUL,
    SHAPE_LONG,
    SHAPE_NOISE
  } line_shape_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic [7:0]        out_data_byte;
  logic              out_is_status;
  logic [1:0]        out_line_status;
  logic [5:0]        out_payload_length;
  logic              out_last;

  line_result_tracker tracker;

  // The line being built, and the CRC of its text so far, which gives the
  // checksum that a well-formed line carries after its star.
  logic [7:0]  line_bytes[$];
  logic [7:0]  line_crc;
  int unsigned counted_items;
  int          gap_pct;
  bit          calm;
  bit          long_hold_pending;

  line_deframer_crc8_check_top #(
    .LINE_BYTES(TB_LINE_BYTES)
  ) u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data_byte     (out_data_byte),
    .out_is_status     (out_is_status),
    .out_line_status   (out_line_status),
    .out_payload_length(out_payload_length),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs on either channel.
  initial begin
    #(RUN_LIMIT_NS);
    $display("line_deframer_crc8_check_top_tb: FAIL");
    $finish;
  end

  // Appends a byte, now and then preceded by a carriage return, which the
  // block must discard without trace.
  function void put_raw(input logic [7:0] b);
    if ($urandom_range(0, 11) == 0) line_bytes.push_back(CH_CR);
    line_bytes.push_back(b);
  endfunction

  // Appends a byte that belongs to the checksummed text of the line.
  function void put_text(input logic [7:0] b);
    put_raw(b);
    line_crc = crc8_fold(line_crc, b);
  endfunction

  // Any byte that is ordinary text: not a line feed, carriage return, star or zero.
  function logic [7:0] pick_text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255));
    while (b == CH_LF || b == CH_CR || b == CH_STAR);
    return b;
  endfunction

  function logic [7:0] hex_char(input logic [3:0] n, input bit upper);
    if (n < 10) return "0" + n;
    return 8'((upper ? "A" : "a") + n - 10);
  endfunction

  // Writes a checksum in hex. Digits beyond two are leading ones, which the
  // modulo-256 folding pushes out again; a single digit gives the low nibble.
  function void put_checksum(input logic [7:0] value, input int digits, input bit upper);
    for (int i = 2; i < digits; i++) put_raw(hex_char(4'($urandom_range(0, 15)), upper));
    if (digits >= 2) put_raw(hex_char(value[7:4], upper));
    put_raw(hex_char(value[3:0], upper));
  endfunction

  // Star and checksum of the text so far: mostly right, sometimes corrupted,
  // sometimes behind a 0x prefix, and sometimes with trailing characters.
  function void put_star_and_checksum();
    logic [7:0] value;
    int         digits;
    value = line_crc;
    if ($urandom_range(0, 4) == 0) value ^= 8'($urandom_range(1, 255));
    digits = (value < 16 && $urandom_range(0, 1) == 0) ? 1 : $urandom_range(2, 4);
    put_raw(CH_STAR);
    if ($urandom_range(0, 9) == 0) begin
      put_raw("0");
      put_raw("x");
    end
    put_checksum(value, digits, 1'($urandom_range(0, 1)));
    case ($urandom_range(0, 5))
      0: begin
        put_raw(" ");
        put_raw(hex_char(4'($urandom_range(0, 15)), 1'b0));
      end
      1: begin
        put_raw("-");
        put_raw(hex_char(4'($urandom_range(0, 15)), 1'b1));
      end
      2: put_raw(pick_text_byte());
      default: ;
    endcase
  endfunction

  // Most random lines are well formed with random content, since those reach
  // the checksum compare and the payload transfers; the rest are broken or
  // pure noise.
  function void put_random_line();
    int          pick;
    int          n;
    line_shape_t shape;
    pick = $urandom_range(0, 99);
    if (pick < 40) shape = SHAPE_CHECKED;
    else if (pick < 58) shape = SHAPE_PLAIN;
    else if (pick < 70) shape = SHAPE_MULTI_STAR;
    else if (pick < 80) shape = SHAPE_NUL;
    else if (pick < 86) shape = SHAPE_LONG;
    else shape = SHAPE_NOISE;
    case (shape)
      SHAPE_CHECKED: begin
        n = $urandom_range(0, 12);
        repeat (n) put_text(pick_text_byte());
        put_star_and_checksum();
      end
      SHAPE_PLAIN: begin
        n = $urandom_range(0, 15);
        repeat (n) put_text(pick_text_byte());
      end
      SHAPE_MULTI_STAR: begin
        // Earlier stars are payload; only the last one opens the checksum.
        repeat ($urandom_range(1, 2)) begin
          n = $urandom_range(0, 5);
          repeat (n) put_text(pick_text_byte());
          put_text(CH_STAR);
          if ($urandom_range(0, 2) == 0) put_text(hex_char(4'($urandom_range(0, 15)), 1'b0));
        end
        n = $urandom_range(0, 5);
        repeat (n) put_text(pick_text_byte());
        put_star_and_checksum();
      end
      SHAPE_NUL: begin
        n = $urandom_range(0, 8);
        repeat (n) put_text(pick_text_byte());
        put_raw(CH_NUL);
        n = $urandom_range(0, 6);
        repeat (n) begin
          if ($urandom_range(0, 2) == 0) put_raw(CH_STAR);
          else put_raw(pick_text_byte());
        end
      end
      SHAPE_LONG: begin
        // Around the capacity of the store, so that the star and checksum
        // are sometimes dropped along with everything else past the limit.
        n = $urandom_range(50, 70);
        repeat (n) put_text(pick_text_byte());
        put_star_and_checksum();
      end
      default: begin
        // Raw noise; any line feed in it simply closes a line early.
        n = $urandom_range(1, 20);
        repeat (n) put_raw(8'($urandom_range(0, 255)));
      end
    endcase
    line_bytes.push_back(CH_LF);
  endfunction

  // Offers one byte and holds it until the block takes it. A gap, if any,
  // comes before valid is raised, never while a byte is on offer.
  task automatic send_rx_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    tracker.note_rx_byte(b);
    counted_items++;
  endtask

  // Sends the line built so far. About a third of the lines go out without
  // any gaps, so that back-to-back transfers are well exercised too.
  task automatic send_line();
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
    foreach (line_bytes[i]) send_rx_byte(line_bytes[i]);
    line_bytes.delete();
    line_crc = CRC_INIT;
  endtask

  task automatic run_directed();
    // An empty line still gives its status transfer.
    line_bytes.push_back(CH_LF);
    send_line();
    // A zero byte ends the usable text; the star after it does not count.
    put_text(8'hFF);
    put_text(CH_NUL);
    put_text("z");
    put_raw(CH_STAR);
    put_raw("1");
    line_bytes.push_back(CH_LF);
    send_line();
    // The x of a 0x prefix stops the digits, leaving a checksum of zero,
    // which matches the CRC of an empty payload.
    put_raw(CH_STAR);
    put_raw("0");
    put_raw("x");
    put_raw("5");
    line_bytes.push_back(CH_LF);
    send_line();
    // Three upper-case digits fold modulo 256; a carriage return precedes
    // the line feed.
    put_text("Q");
    put_raw(CH_STAR);
    put_checksum(line_crc, 3, 1'b1);
    line_bytes.push_back(CH_CR);
    line_bytes.push_back(CH_LF);
    send_line();
    // Two stars, the checksum after the last one stopped at once by a sign.
    put_text("a");
    put_text(CH_STAR);
    put_text("b");
    put_raw(CH_STAR);
    put_raw("+");
    put_raw("1");
    line_bytes.push_back(CH_LF);
    send_line();
  endtask

  // Receiver side: short random stalls, longer stretches of readiness, and
  // one long hold-off after the directed lines so that the block has to stall
  // its input while the sender keeps offering bytes.
  initial begin
    out_ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_pending) begin
        long_hold_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Every result transfer is checked against the oldest awaited result.
  always @(posedge clk) begin : result_monitor
    line_item_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.data_byte      = out_data_byte;
      seen.is_status      = out_is_status;
      seen.line_status    = out_line_status;
      seen.payload_length = out_payload_length;
      seen.last           = out_last;
      tracker.check_line_item(seen);
    end
  end

  initial begin : main_sequence
    int waited;
    tracker           = new();
    in_valid          = 1'b0;
    in_rx_byte        = 8'h00;
    rst_n             = 1'b0;
    calm              = 1'b0;
    long_hold_pending = 1'b0;
    counted_items     = 0;
    gap_pct           = 0;
    line_crc          = CRC_INIT;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    long_hold_pending = 1'b1;
    while (counted_items < TARGET_ITEMS) begin
      if (counted_items + CALM_ITEMS >= TARGET_ITEMS) calm = 1'b1;
      put_random_line();
      send_line();
    end
    in_valid <= 1'b0;

    // Let the last line drain, then wait out the settle time for anything stray.
    waited = 0;
    while (tracker.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.flag_mismatch($sformatf("%0d results never arrived", tracker.pending()));

    if (tracker.mismatch_count == 0) $display("line_deframer_crc8_check_top_tb: PASS");
    else $display("line_deframer_crc8_check_top_tb: FAIL");
    $finish;
  end

endmodule
